/* sv/kpu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kpu_pkg
// Shared types and constants for the permutation unranking block.
// ----------------------------------------------------------------------------
package kpu_pkg;

    localparam int LEN_W  = 4;
    localparam int RANK_W = 29;
    localparam int FACT_W = RANK_W + 1;
    localparam int SLOTS  = 1 << LEN_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Factorials 0!..15!; anything past 12! is clipped to all ones, which
    // is above every representable rank.
    localparam logic [FACT_W-1:0] FACT_SAT = {FACT_W{1'b1}};
    localparam logic [FACT_W-1:0] FACT_TBL [SLOTS] = '{
        30'd1, 30'd1, 30'd2, 30'd6, 30'd24, 30'd120, 30'd720, 30'd5040,
        30'd40320, 30'd362880, 30'd3628800, 30'd39916800, 30'd479001600,
        FACT_SAT, FACT_SAT, FACT_SAT
    };

    typedef struct packed {
        logic [LEN_W-1:0]  n;
        logic [RANK_W-1:0] km1;
        logic              err;
    } t_job;

    typedef struct packed {
        logic [LEN_W-1:0] value;
        logic [LEN_W-1:0] position;
        logic             last;
        logic             err;
    } t_result;

    // Lowest set bit of mask; zero when none is set.
    function automatic logic [LEN_W-1:0] first_set(input logic [SLOTS-1:0] mask);
        logic [LEN_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (mask[i]) idx = LEN_W'(i);
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

/* sv/kpu_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kpu_front
// Captures an item, range-checks it and forms k-1 for the decoder.
// ----------------------------------------------------------------------------
module kpu_front #(
    parameter int MAX_N = 12
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_take,
    input  wire [kpu_pkg::LEN_W-1:0]    i_perm_length,
    input  wire [kpu_pkg::RANK_W-1:0]   i_rank,
    input  wire                         i_q_full,
    output logic                        o_held,
    output logic                        o_push,
    output kpu_pkg::t_job               o_job
);
    import kpu_pkg::*;

    logic              r_valid;
    logic [LEN_W-1:0]  r_n;
    logic [RANK_W-1:0] r_k;
    logic              w_err;

    always_comb begin
        w_err = (r_n == '0) || (int'(r_n) > MAX_N) || (r_k == '0)
              || ({1'b0, r_k} > FACT_TBL[r_n]);
        o_job.n   = r_n;
        o_job.km1 = r_k - RANK_W'(1);
        o_job.err = w_err;
    end

    assign o_push = r_valid && !i_q_full;
    assign o_held = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (i_take) begin
            r_n <= i_perm_length;
            r_k <= i_rank;
        end
    end

endmodule
`default_nettype wire

/* sv/kpu_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kpu_queue
// Small register queue of classified items between front and decoder.
// ----------------------------------------------------------------------------
module kpu_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  kpu_pkg::t_job   i_job,
    input  wire             i_pop,
    output logic            o_full,
    output logic            o_empty,
    output kpu_pkg::t_job   o_job
);
    import kpu_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + QPTR_W'(1);
            if (w_pop)  r_rd <= r_rd + QPTR_W'(1);
            if (w_push && !w_pop)      r_cnt <= r_cnt + QCNT_W'(1);
            else if (w_pop && !w_push) r_cnt <= r_cnt - QCNT_W'(1);
        end
        if (w_push) r_mem[r_wr] <= i_job;
    end

endmodule
`default_nettype wire

/* sv/kpu_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kpu_back
// Factorial-base decoder: one compare-subtract per cycle per digit, with a
// pointer that walks the unused values alongside the quotient.
// ----------------------------------------------------------------------------
module kpu_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_empty,
    input  kpu_pkg::t_job       i_job,
    output logic                o_pop,
    output logic                o_valid,
    output kpu_pkg::t_result    o_res
);
    import kpu_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SETUP, S_DIV} t_state;

    t_state            r_state;
    logic [LEN_W-1:0]  r_n;
    logic [LEN_W-1:0]  r_pos;
    logic [LEN_W-1:0]  r_ptr;
    logic [RANK_W-1:0] r_rem;
    logic [FACT_W-1:0] r_f;
    logic [SLOTS-1:0]  r_used;

    logic [SLOTS-1:0]  w_above;
    logic              w_ge;
    logic              w_last;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_above[i] = (LEN_W'(i) > r_ptr);
        end
        w_ge   = ({1'b0, r_rem} >= r_f);
        w_last = (r_pos == r_n - LEN_W'(1));
    end

    assign o_pop = (r_state == S_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        if (i_job.err) begin
                            o_valid <= 1'b1;
                            o_res   <= '{value: '0, position: '0, last: 1'b1, err: 1'b1};
                        end else begin
                            r_n     <= i_job.n;
                            r_rem   <= i_job.km1;
                            r_pos   <= '0;
                            r_used  <= '0;
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    r_f     <= FACT_TBL[r_n - r_pos - LEN_W'(1)];
                    r_ptr   <= first_set(~r_used);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_ge) begin
                        // one more step into the free list
                        r_rem <= r_rem - r_f[RANK_W-1:0];
                        r_ptr <= first_set(~r_used & w_above);
                    end else begin
                        o_valid       <= 1'b1;
                        o_res         <= '{value: r_ptr + LEN_W'(1), position: r_pos,
                                           last: w_last, err: 1'b0};
                        r_used[r_ptr] <= 1'b1;
                        r_pos         <= r_pos + LEN_W'(1);
                        r_state       <= w_last ? S_IDLE : S_SETUP;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* sv/kth_permutation_unrank.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kth_permutation_unrank
// Emits the k-th lexicographic permutation of 1..n, one element per strobe.
// ----------------------------------------------------------------------------
// Raise start with perm_length n and a one-based rank k; the item is taken
// when busy is low. Results leave one per o_valid strobe, in position order,
// with o_last_element on the final one; a zero rank, a rank above n! or a
// length outside 1..MAX_N gives a single result with o_range_error and
// o_last_element set. Results cannot be held off, so sample each strobe.
// The front registers the item, checks it and parks it in a two-entry queue,
// so a second item can be taken while the decoder works. The decoder takes
// an item from the queue in its idle state, then spends a setup state and a
// divide state on each element, where the factorial-base digit q is worked
// off by a single compare-subtract per cycle; an error item gives its result
// straight from the idle state.
// ----------------------------------------------------------------------------
module kth_permutation_unrank #(
    parameter int MAX_N = 12
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire [kpu_pkg::LEN_W-1:0]    i_perm_length,
    input  wire [kpu_pkg::RANK_W-1:0]   i_rank,
    output logic                        o_valid,
    output logic [kpu_pkg::LEN_W-1:0]   o_element_value,
    output logic [kpu_pkg::LEN_W-1:0]   o_position,
    output logic                        o_last_element,
    output logic                        o_range_error
);
    import kpu_pkg::*;

    logic    w_held;
    logic    w_push;
    t_job    w_fjob;
    logic    w_full;
    logic    w_empty;
    t_job    w_qjob;
    logic    w_pop;
    t_result w_res;

    assign busy = w_held || w_full;

    kpu_front #(.MAX_N(MAX_N)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (start && !busy),
        .i_perm_length (i_perm_length),
        .i_rank        (i_rank),
        .i_q_full      (w_full),
        .o_held        (w_held),
        .o_push        (w_push),
        .o_job         (w_fjob)
    );

    kpu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_qjob)
    );

    kpu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_job     (w_qjob),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .o_res     (w_res)
    );

    assign o_element_value = w_res.value;
    assign o_position      = w_res.position;
    assign o_last_element  = w_res.last;
    assign o_range_error   = w_res.err;

    // an error result is always alone and carries no element
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_last_element && o_element_value == '0)
        else $error("error result not a lone empty result");

    // a taken item is held in the front until it reaches the queue
    a_take_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an item was taken");

    // a good element lies within 1..MAX_N and its position below MAX_N
    a_elem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_range_error |-> o_element_value != '0
            && int'(o_position) < MAX_N && int'(o_element_value) <= MAX_N)
        else $error("element out of range");

    // the queue never reports full and empty together
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_full && w_empty))
        else $error("queue full and empty at once");

endmodule
`default_nettype wire
